>>> hw/rtl/lbcs_pkg.sv
// Shared types, codes and constants for the LED blink code sequencer.
package lbcs_pkg;

    // Request kinds carried in the low bits of an input beat
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_EVAL  = 2'd1,
        REQ_ABORT = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_BLINK_COUNT = 3'd0,
        CFG_BLINK_COLOR = 3'd1,
        CFG_ON_TIME     = 3'd2,
        CFG_OFF_TIME    = 3'd3,
        CFG_LEAD_BLANK  = 3'd4,
        CFG_TRAIL_BLANK = 3'd5,
        CFG_RSVD6       = 3'd6,
        CFG_RSVD7       = 3'd7
    } cfg_idx_t;

    localparam int TICK_SHIFT = 5;  // one tick is 32 ms

    localparam logic [3:0] LED_OFF = 4'b0000;

    localparam logic [6:0]  BLINK_COUNT_RST = 7'd0;
    localparam logic [3:0]  BLINK_COLOR_RST = 4'd9;
    localparam logic [15:0] ON_TIME_RST     = 16'd250;
    localparam logic [15:0] OFF_TIME_RST    = 16'd250;
    localparam logic [15:0] LEAD_BLANK_RST  = 16'd750;
    localparam logic [15:0] TRAIL_BLANK_RST = 16'd500;

    typedef struct packed {
        logic [6:0]  blink_count;
        logic [3:0]  blink_color;
        logic [15:0] on_time_ms;
        logic [15:0] off_time_ms;
        logic [15:0] lead_blank_ms;
        logic [15:0] trail_blank_ms;
    } cfg_t;

    typedef struct packed {
        logic [15:0] tick_count;
        logic        active;
        logic [7:0]  step_index;
        logic [7:0]  last_step;
        logic [15:0] deadline_ms;
        logic [3:0]  lit_mask;
        logic [7:0]  code_counter;
        logic        count_enabled;
    } seq_state_t;

endpackage

>>> hw/rtl/led_blink_code_sequencer.sv
// Top level of the LED blink code sequencer: handshakes, registers, result stage.
//
// Channel  Dir  Handshake                 Payload
// s_       in   s_tvalid / s_tready       s_tdata: req_type[1:0], count_codes[2]
// m_       out  m_tvalid / m_tready       m_tdata: led_mask[3:0], running[4],
//                                                  codes_started[12:5]
// cfg_     in   cfg_valid / cfg_ready     cfg_index (register), cfg_data
//
// Each input beat is handled combinationally: the next-state logic sits between
// the sequencer state register and the result register, so a beat can be
// taken every cycle while the result stage is empty or being drained.
// A stall on m_ holds the pending result; s_tready drops only while that
// result is held. cfg_ready is always high. Reset (aresetn low, synchronous)
// restores register defaults, clears the sequencer state and drops m_tvalid.
module led_blink_code_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    // input request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [1:0] req_type, [2] count_codes, rest zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] led_mask, [4] running, [12:5] codes_started
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lbcs_pkg::*;

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    logic       m_valid_reg;
    logic [15:0] m_data_reg;
    logic       s_accept;
    req_t       req;

    assign req       = req_t'(s_tdata[1:0]);
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    lbcs_engine u_engine (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .req         (req),
        .count_codes (s_tdata[2]),
        .nxt         (state_next)
    );

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_count    <= BLINK_COUNT_RST;
            cfg_reg.blink_color    <= BLINK_COLOR_RST;
            cfg_reg.on_time_ms     <= ON_TIME_RST;
            cfg_reg.off_time_ms    <= OFF_TIME_RST;
            cfg_reg.lead_blank_ms  <= LEAD_BLANK_RST;
            cfg_reg.trail_blank_ms <= TRAIL_BLANK_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BLINK_COUNT: cfg_reg.blink_count    <= cfg_data[6:0];
                CFG_BLINK_COLOR: cfg_reg.blink_color    <= cfg_data[3:0];
                CFG_ON_TIME:     cfg_reg.on_time_ms     <= cfg_data;
                CFG_OFF_TIME:    cfg_reg.off_time_ms    <= cfg_data;
                CFG_LEAD_BLANK:  cfg_reg.lead_blank_ms  <= cfg_data;
                CFG_TRAIL_BLANK: cfg_reg.trail_blank_ms <= cfg_data;
                CFG_RSVD6, CFG_RSVD7: ;
                default: ;
            endcase
        end
    end

    // sequencer state advances once per accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // result stage: reports the state left by the beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_data_reg <= {3'b000, state_next.code_counter, state_next.active,
                           state_next.lit_mask};
        end
    end

endmodule

>>> hw/rtl/lbcs_engine.sv
// Next-state logic of the blink sequencer for one request beat.
module lbcs_engine (
    input  lbcs_pkg::seq_state_t cur,
    input  lbcs_pkg::cfg_t       cfg,
    input  lbcs_pkg::req_t       req,
    input  logic                 count_codes,
    output lbcs_pkg::seq_state_t nxt
);
    import lbcs_pkg::*;

    logic [15:0] now_ms;
    logic [8:0]  step_inc;

    assign now_ms   = 16'(cur.tick_count << TICK_SHIFT);
    assign step_inc = {1'b0, cur.step_index} + 9'd1;

    always_comb begin
        nxt = cur;
        unique case (req)
            REQ_TICK: begin
                if (cur.active) begin
                    nxt.tick_count = cur.tick_count + 16'd1;
                end
            end
            REQ_EVAL: begin
                if (count_codes) begin
                    nxt.count_enabled = 1'b1;
                end
                if (!cur.active) begin
                    // start: elapsed time is zero, so no step in the same beat
                    nxt.lit_mask    = LED_OFF;
                    nxt.tick_count  = '0;
                    nxt.active      = 1'b1;
                    nxt.last_step   = {cfg.blink_count, 1'b1};
                    nxt.step_index  = '0;
                    nxt.deadline_ms = cfg.lead_blank_ms;
                    if (nxt.count_enabled) begin
                        nxt.code_counter = cur.code_counter + 8'd1;
                    end
                end else if (now_ms > cur.deadline_ms) begin
                    priority if (cur.step_index == 8'd0) begin
                        nxt.step_index = 8'd1;
                        if (cfg.blink_count != 7'd0) begin
                            nxt.lit_mask = cfg.blink_color;
                        end
                        nxt.deadline_ms = cur.deadline_ms + cfg.on_time_ms;
                    end else if (step_inc == {1'b0, cur.last_step}) begin
                        nxt.step_index  = step_inc[7:0];
                        nxt.lit_mask    = LED_OFF;
                        nxt.deadline_ms = cur.deadline_ms + cfg.trail_blank_ms;
                    end else if (cur.step_index == cur.last_step) begin
                        nxt.lit_mask   = LED_OFF;
                        nxt.active     = 1'b0;
                        nxt.tick_count = '0;
                    end else if (cur.step_index[0]) begin
                        nxt.step_index  = step_inc[7:0];
                        nxt.lit_mask    = LED_OFF;
                        nxt.deadline_ms = cur.deadline_ms + cfg.off_time_ms;
                    end else begin
                        nxt.step_index  = step_inc[7:0];
                        nxt.lit_mask    = cfg.blink_color;
                        nxt.deadline_ms = cur.deadline_ms + cfg.on_time_ms;
                    end
                end
            end
            REQ_ABORT: begin
                nxt.lit_mask      = LED_OFF;
                nxt.active        = 1'b0;
                nxt.tick_count    = '0;
                nxt.count_enabled = 1'b0;
                nxt.code_counter  = '0;
            end
            REQ_NONE: begin
                nxt = cur;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule
